FILE: rtl/fpdp_pkg.sv
// ----------------------------------------------------------------------------
// fpdp_pkg: shared types and helpers for the half-precision dot product
// Holds the product record passed between stages and a leading-zero counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpdp_pkg;

	localparam logic [31:0] CANON_QNAN = 32'h7FC0_0000;
	localparam logic [7:0]  EXP_BIAS_ADJ = 8'd98;

	typedef struct packed {
		logic        nan;
		logic        inf;
		logic        zero;
		logic        sign;
		logic [7:0]  exp;
		logic [23:0] sig;
	} prod_t;

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		logic       found;
		n = 5'd27;
		found = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 5'(26 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/fpdp_mul.sv
// ----------------------------------------------------------------------------
// fpdp_mul: operand decode and exact significand product
// Widens both binary16 operands and forms their exact product and flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpdp_mul (
	input  wire logic [15:0]     a_half,
	input  wire logic [15:0]     b_half,
	output fpdp_pkg::prod_t      prod
);

	logic [4:0]  ea, eb;
	logic [9:0]  ma, mb;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [10:0] siga, sigb;
	logic [4:0]  ea_eff, eb_eff;
	logic [21:0] sig_prod;

	always_comb begin
		ea = a_half[14:10];
		eb = b_half[14:10];
		ma = a_half[9:0];
		mb = b_half[9:0];
		a_nan  = (ea == 5'h1F) && (ma != 10'd0);
		b_nan  = (eb == 5'h1F) && (mb != 10'd0);
		a_inf  = (ea == 5'h1F) && (ma == 10'd0);
		b_inf  = (eb == 5'h1F) && (mb == 10'd0);
		a_zero = (ea == 5'd0) && (ma == 10'd0);
		b_zero = (eb == 5'd0) && (mb == 10'd0);
		siga   = {(ea != 5'd0), ma};
		sigb   = {(eb != 5'd0), mb};
		ea_eff = (ea == 5'd0) ? 5'd1 : ea;
		eb_eff = (eb == 5'd0) ? 5'd1 : eb;
		sig_prod = siga * sigb;

		prod.nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
		prod.inf  = a_inf || b_inf;
		prod.zero = a_zero || b_zero;
		prod.sign = a_half[15] ^ b_half[15];
		prod.exp  = {3'b000, ea_eff} + {3'b000, eb_eff} + fpdp_pkg::EXP_BIAS_ADJ;
		prod.sig  = {sig_prod, 2'b00};
	end

endmodule

`default_nettype wire

FILE: rtl/fpdp_norm.sv
// ----------------------------------------------------------------------------
// fpdp_norm: product normaliser
// Shifts the raw product so that its leading one sits at the hidden bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpdp_norm (
	input  fpdp_pkg::prod_t raw,
	output fpdp_pkg::prod_t norm
);

	logic [4:0] lz;

	always_comb begin
		lz   = fpdp_pkg::lzc27({raw.sig, 3'b000});
		norm = raw;
		if (raw.zero) begin
			norm.exp = 8'd1;
			norm.sig = 24'd0;
		end else begin
			norm.exp = raw.exp - {3'b000, lz};
			norm.sig = raw.sig << lz;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/fpdp_add.sv
// ----------------------------------------------------------------------------
// fpdp_add: single-precision accumulate adder
// Adds a normalised product to the accumulator with round-to-nearest-even.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpdp_add (
	input  wire logic [31:0] acc,
	input  fpdp_pkg::prod_t  prod,
	output logic [31:0]      sum
);

	logic [7:0]  acc_ex, acc_e, e_big, e_small, d, lim;
	logic [23:0] acc_sig, m_big, m_small;
	logic        acc_nan, acc_inf, swap, s_big, eff_sub, rnd_up;
	logic [4:0]  dc, lz, sh_l;
	logic [50:0] shifted;
	logic [26:0] aligned, big_ext, n;
	logic [27:0] r;
	logic [8:0]  e_res, field;
	logic [24:0] m_rnd;
	logic [22:0] frac;

	always_comb begin
		acc_ex  = acc[30:23];
		acc_nan = (acc_ex == 8'hFF) && (acc[22:0] != 23'd0);
		acc_inf = (acc_ex == 8'hFF) && (acc[22:0] == 23'd0);
		acc_sig = {(acc_ex != 8'd0), acc[22:0]};
		acc_e   = (acc_ex == 8'd0) ? 8'd1 : acc_ex;

		swap    = {prod.exp, prod.sig} > {acc_e, acc_sig};
		s_big   = swap ? prod.sign : acc[31];
		e_big   = swap ? prod.exp : acc_e;
		m_big   = swap ? prod.sig : acc_sig;
		e_small = swap ? acc_e : prod.exp;
		m_small = swap ? acc_sig : prod.sig;
		eff_sub = acc[31] ^ prod.sign;

		d       = e_big - e_small;
		dc      = (d > 8'd27) ? 5'd27 : d[4:0];
		shifted = {m_small, 27'd0} >> dc;
		aligned = {shifted[50:25], |shifted[24:0]};
		big_ext = {m_big, 3'b000};
		r = eff_sub ? ({1'b0, big_ext} - {1'b0, aligned})
		            : ({1'b0, big_ext} + {1'b0, aligned});

		lz   = fpdp_pkg::lzc27(r[26:0]);
		lim  = e_big - 8'd1;
		sh_l = ({3'b000, lz} < lim) ? lz : lim[4:0];
		if (r[27]) begin
			n     = {r[27:2], r[1] | r[0]};
			e_res = {1'b0, e_big} + 9'd1;
		end else begin
			n     = r[26:0] << sh_l;
			e_res = {1'b0, e_big} - {4'b0000, sh_l};
		end

		rnd_up = n[2] & (n[1] | n[0] | n[3]);
		m_rnd  = {1'b0, n[26:3]} + {24'd0, rnd_up};
		if (m_rnd[24]) begin
			field = e_res + 9'd1;
			frac  = m_rnd[23:1];
		end else begin
			field = m_rnd[23] ? e_res : 9'd0;
			frac  = m_rnd[22:0];
		end

		if (acc_nan || prod.nan || (acc_inf && prod.inf && eff_sub)) begin
			sum = fpdp_pkg::CANON_QNAN;
		end else if (acc_inf) begin
			sum = acc;
		end else if (prod.inf) begin
			sum = {prod.sign, 8'hFF, 23'd0};
		end else if (r == 28'd0) begin
			sum = {acc[31] & prod.sign, 31'd0};
		end else if (field >= 9'd255) begin
			sum = {s_big, 8'hFF, 23'd0};
		end else begin
			sum = {s_big, field[7:0], frac};
		end
	end

endmodule

`default_nettype wire

FILE: rtl/fp16_dot_product_f32_accumulate.sv
// ----------------------------------------------------------------------------
// fp16_dot_product_f32_accumulate: half-precision dot product, f32 accumulate
// Multiplies binary16 pairs exactly and accumulates in binary32 per run.
// A run's result is registered in out_q after its tlast beat passes the s1, s2 and s3 registers.
// Throughput: one beat per cycle unless stalled; the accumulator loop is one adder pass.
// The pipeline stalls only while a beat carrying tlast waits behind a held result.
// Reset clears all valid flags and sets the accumulator to +0.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fp16_dot_product_f32_accumulate (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // a_half [15:0], b_half [31:16]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata   // sum_bits [31:0]
);

	logic [15:0]     a_s1, b_s1;
	logic            last_s1, last_s2, last_s3;
	logic            v_s1, v_s2, v_s3;
	fpdp_pkg::prod_t prod_raw, prod_s2, prod_nrm, prod_s3;
	logic [31:0]     acc_q, sum, out_q;
	logic            out_v_q;
	logic            adv3, en3, en2, en1;

	fpdp_mul u_mul (.a_half(a_s1), .b_half(b_s1), .prod(prod_raw));
	fpdp_norm u_norm (.raw(prod_s2), .norm(prod_nrm));
	fpdp_add u_add (.acc(acc_q), .prod(prod_s3), .sum(sum));

	always_comb begin
		adv3 = v_s3 && (!last_s3 || !out_v_q || m_tready);
		en3  = !v_s3 || adv3;
		en2  = !v_s2 || en3;
		en1  = !v_s1 || en2;
	end

	assign s_tready = en1;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
			acc_q   <= 32'd0;
		end else begin
			if (en1) begin
				v_s1 <= s_tvalid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (adv3) begin
				acc_q <= last_s3 ? 32'd0 : sum;
			end
			if (adv3 && last_s3) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			a_s1    <= s_tdata[15:0];
			b_s1    <= s_tdata[31:16];
			last_s1 <= s_tlast;
		end
		if (en2) begin
			prod_s2 <= prod_raw;
			last_s2 <= last_s1;
		end
		if (en3) begin
			prod_s3 <= prod_nrm;
			last_s3 <= last_s2;
		end
		if (adv3 && last_s3) begin
			out_q <= sum;
		end
	end

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv3 && last_s3) |=> (acc_q == 32'd0))
		else $error("accumulator not cleared after the last beat");

	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[30:23] == 8'hFF) && (m_tdata[22:0] != 23'd0))
			|-> (m_tdata == fpdp_pkg::CANON_QNAN))
		else $error("result NaN is not canonical");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("held result was overwritten");

endmodule

`default_nettype wire
